[hw/rtl/jdsc_pkg.sv]
// jdsc_pkg: codes, reset values and joystick scaling for the drive safety controller
`default_nettype none

package jdsc_pkg;

   // joystick direction codes
   localparam logic [2:0] DIR_COAST = 3'd0;
   localparam logic [2:0] DIR_FWD   = 3'd1;
   localparam logic [2:0] DIR_BWD   = 3'd2;
   localparam logic [2:0] DIR_LEFT  = 3'd3;
   localparam logic [2:0] DIR_RIGHT = 3'd4;

   // motor mode codes
   localparam logic [1:0] MODE_COAST = 2'd0;
   localparam logic [1:0] MODE_STOP  = 2'd1;
   localparam logic [1:0] MODE_FWD   = 2'd2;
   localparam logic [1:0] MODE_BWD   = 2'd3;

   // stop cause codes
   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_LINK     = 3'd1;
   localparam logic [2:0] CAUSE_EMERG    = 3'd2;
   localparam logic [2:0] CAUSE_SENSOR   = 3'd3;
   localparam logic [2:0] CAUSE_OBSTACLE = 3'd4;

   // register indexes on the csr port
   localparam logic [2:0] CSR_X_CENTER    = 3'd0;
   localparam logic [2:0] CSR_Y_CENTER    = 3'd1;
   localparam logic [2:0] CSR_DEAD_BAND   = 3'd2;
   localparam logic [2:0] CSR_DRIVE_SPEED = 3'd3;
   localparam logic [2:0] CSR_NEAR_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd5;

   // register reset values
   localparam logic [7:0]  RST_X_CENTER    = 8'd126;
   localparam logic [7:0]  RST_Y_CENTER    = 8'd121;
   localparam logic [6:0]  RST_DEAD_BAND   = 7'd40;
   localparam logic [7:0]  RST_DRIVE_SPEED = 8'd255;
   localparam logic [14:0] RST_NEAR_LIMIT  = 15'd128;
   localparam logic [15:0] RST_TIMEOUT     = 16'd300;

   // v*255/1023 == v*85/341; 1/341 taken as 196801 / 2^26, exact for v < 1024
   localparam int unsigned ScaleShift = 26;
   localparam logic [23:0] ScaleMul   = 24'(85 * 196801);

   // scale a raw 10-bit stick reading to 0..255, truncated
   function automatic logic [7:0] scale10(input logic [9:0] raw);
      logic [33:0] prod;
      prod = 34'(raw) * 34'(ScaleMul);
      return prod[ScaleShift+7:ScaleShift];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/joystick_drive_safety_controller.sv]
// joystick_drive_safety_controller: direction pick, safety stop rules and output register
//
//   channel  handshake            payload
//   req      req_valid/req_stall  now_ms, stick x/y raw, emergency word, link, distance
//   rsp      rsp_valid/rsp_stall  motor modes, speed, brake light, direction, cause
//   csr      csr_valid/csr_ready  csr_index (3 bits), csr_data (16 bits)
//
// An item is accepted into the input register and moves to the result register as soon
// as that is empty or not stalled; one item per cycle is sustained while rsp_stall is low.
// Between the two registers sit one 10x24 scaling multiply per axis and the compare and
// priority logic; the invalid-distance timer updates as an item moves on. Synchronous
// reset clears the control state and the timer and loads the register defaults.
// req_stall rises only while the input register is full and rsp_stall holds the result.
`default_nettype none

module joystick_drive_safety_controller
   import jdsc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // input items
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic [9:0]         req_stick_x_raw,
   input  wire logic [9:0]         req_stick_y_raw,
   input  wire logic [15:0]        req_emergency_word,
   input  wire logic               req_link_up,
   input  wire logic signed [15:0] req_front_distance,
   // result items
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_left_mode,
   output logic [1:0]              rsp_right_mode,
   output logic [7:0]              rsp_motor_speed,
   output logic                    rsp_brake_light,
   output logic [2:0]              rsp_commanded_direction,
   output logic [2:0]              rsp_stop_cause,
   // register writes
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   // configuration registers
   logic [7:0]  x_center_ff, y_center_ff, drive_speed_ff;
   logic [6:0]  dead_band_ff;
   logic [14:0] near_limit_ff;
   logic [15:0] timeout_ff;

   // input register
   logic               in_valid_ff;
   logic [31:0]        now_ff;
   logic [9:0]         x_raw_ff, y_raw_ff;
   logic [15:0]        emerg_ff;
   logic               link_ff;
   logic signed [15:0] dist_ff;

   // timer state
   logic        timing_ff, timing_in;
   logic [31:0] start_ff, start_in;

   // result register
   logic       out_valid_ff;
   logic [1:0] left_ff, right_ff, left_in, right_in;
   logic [7:0] speed_ff, speed_in;
   logic       brake_ff, brake_in;
   logic [2:0] dir_ff, cause_ff, cause_in;

   logic       out_free, advance, take_req;

   // datapath intermediates
   logic [7:0]  x_val, y_val;
   logic [8:0]  x_up_sum, y_up_sum;
   logic [7:0]  x_up, y_up, x_lo, y_lo;
   logic [2:0]  dir;
   logic        dist_invalid, near, timed_out;
   logic [31:0] start_eff, elapsed;

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         x_center_ff    <= RST_X_CENTER;
         y_center_ff    <= RST_Y_CENTER;
         dead_band_ff   <= RST_DEAD_BAND;
         drive_speed_ff <= RST_DRIVE_SPEED;
         near_limit_ff  <= RST_NEAR_LIMIT;
         timeout_ff     <= RST_TIMEOUT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_CENTER:    x_center_ff    <= csr_data[7:0];
            CSR_Y_CENTER:    y_center_ff    <= csr_data[7:0];
            CSR_DEAD_BAND:   dead_band_ff   <= csr_data[6:0];
            CSR_DRIVE_SPEED: drive_speed_ff <= csr_data[7:0];
            CSR_NEAR_LIMIT:  near_limit_ff  <= csr_data[14:0];
            CSR_TIMEOUT:     timeout_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         now_ff   <= req_now_ms;
         x_raw_ff <= req_stick_x_raw;
         y_raw_ff <= req_stick_y_raw;
         emerg_ff <= req_emergency_word;
         link_ff  <= req_link_up;
         dist_ff  <= req_front_distance;
      end
   end

   // scaling and dead band thresholds
   always_comb begin
      x_val    = scale10(x_raw_ff);
      y_val    = scale10(y_raw_ff);
      x_up_sum = {1'b0, x_center_ff} + {2'b00, dead_band_ff};
      y_up_sum = {1'b0, y_center_ff} + {2'b00, dead_band_ff};
      x_up     = x_up_sum[8] ? 8'hFF : x_up_sum[7:0];
      y_up     = y_up_sum[8] ? 8'hFF : y_up_sum[7:0];
      x_lo     = (x_center_ff > {1'b0, dead_band_ff}) ?
                 x_center_ff - {1'b0, dead_band_ff} : 8'd0;
      y_lo     = (y_center_ff > {1'b0, dead_band_ff}) ?
                 y_center_ff - {1'b0, dead_band_ff} : 8'd0;
   end

   // direction pick, y before x
   always_comb begin
      priority if (y_val >= y_up) dir = DIR_FWD;
      else if (y_val <= y_lo)     dir = DIR_BWD;
      else if (x_val >= x_up)     dir = DIR_RIGHT;
      else if (x_val <= x_lo)     dir = DIR_LEFT;
      else                        dir = DIR_COAST;
   end

   // invalid distance timing and obstacle check
   always_comb begin
      dist_invalid = (dist_ff <= 16'sd0);
      near         = !dist_invalid && (dist_ff[14:0] <= near_limit_ff);
      start_eff    = timing_ff ? start_ff : now_ff;
      elapsed      = now_ff - start_eff;
      timed_out    = (elapsed > {16'd0, timeout_ff});
   end

   // safety rules and motor drive
   always_comb begin
      timing_in = timing_ff;
      start_in  = start_ff;
      cause_in  = CAUSE_NONE;
      if (link_ff && (emerg_ff != 16'd1)) begin
         if (dist_invalid) begin
            timing_in = 1'b1;
            start_in  = start_eff;
         end else begin
            timing_in = 1'b0;
         end
      end
      priority if (!link_ff)                           cause_in = CAUSE_LINK;
      else if (emerg_ff == 16'd1)                      cause_in = CAUSE_EMERG;
      else if (dist_invalid && timed_out && dir == DIR_FWD)
                                                       cause_in = CAUSE_SENSOR;
      else if (near && (dir == DIR_FWD || dir == DIR_COAST))
                                                       cause_in = CAUSE_OBSTACLE;
      else                                             cause_in = CAUSE_NONE;

      brake_in = (cause_in != CAUSE_NONE);
      speed_in = drive_speed_ff;
      if (brake_in) begin
         left_in  = MODE_STOP;
         right_in = MODE_STOP;
         speed_in = 8'd0;
      end else begin
         unique case (dir)
            DIR_FWD: begin
               left_in  = MODE_FWD;
               right_in = MODE_FWD;
            end
            DIR_BWD: begin
               left_in  = MODE_BWD;
               right_in = MODE_BWD;
            end
            DIR_LEFT: begin
               left_in  = MODE_BWD;
               right_in = MODE_FWD;
            end
            DIR_RIGHT: begin
               left_in  = MODE_FWD;
               right_in = MODE_BWD;
            end
            default: begin
               left_in  = MODE_COAST;
               right_in = MODE_COAST;
               speed_in = 8'd0;
            end
         endcase
      end
   end

   // timer state updates as an item is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= 1'b0;
         start_ff  <= 32'd0;
      end else if (advance) begin
         timing_ff <= timing_in;
         start_ff  <= start_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         speed_ff <= speed_in;
         brake_ff <= brake_in;
         dir_ff   <= dir;
         cause_ff <= cause_in;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_left_mode           = left_ff;
   assign rsp_right_mode          = right_ff;
   assign rsp_motor_speed         = speed_ff;
   assign rsp_brake_light         = brake_ff;
   assign rsp_commanded_direction = dir_ff;
   assign rsp_stop_cause          = cause_ff;

   // stopping always means brake light on and zero speed
   a_brake_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_cause != CAUSE_NONE |-> rsp_brake_light && rsp_motor_speed == 8'd0)
      else $error("stop without brake or with speed");

   // sensor timeout only blocks forward
   a_sensor_fwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_cause == CAUSE_SENSOR |-> rsp_commanded_direction == DIR_FWD)
      else $error("sensor timeout stop on non-forward item");

   // a valid distance on a live link ends the invalid period
   a_timer_clear: assert property (@(posedge clock) disable iff (reset)
      advance && link_ff && emerg_ff != 16'd1 && !dist_invalid |=> !timing_ff)
      else $error("timer not cleared by valid distance");

   // the timer start holds while an invalid period runs
   a_timer_hold: assert property (@(posedge clock) disable iff (reset)
      advance && timing_ff |=> timing_ff == 1'b0 || start_ff == $past(start_ff))
      else $error("timer start moved during invalid period");

   // result register does not take a new item while held
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !advance)
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire
